// ===== src/reader_writer_lock_table_assert.svh =====
// assertion macros used by reader_writer_lock_table.sv
`ifndef READER_WRITER_LOCK_TABLE_ASSERT_SVH
`define READER_WRITER_LOCK_TABLE_ASSERT_SVH
`define RWLT_ASSERT_IMP(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	(a) |-> (c)) else $error("rwlt check failed");
`define RWLT_ASSERT_NXT(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	(a) |=> (c)) else $error("rwlt check failed");
`endif

// ===== src/rwlt_pkg.sv =====
// ----------------------------------------------------------------------------
// rwlt_pkg
// shared types and codes of the reader/writer lock table
// ----------------------------------------------------------------------------
`default_nettype none
package rwlt_pkg;
	localparam int DEF_ENTRIES = 64;
	localparam logic [15:0] NO_TID  = 16'hffff;
	localparam logic [15:0] ANY_PID = 16'hffff;
	localparam logic [2:0] ST_OK = 3'd0, ST_WAIT = 3'd1, ST_NOENT = 3'd2,
		ST_FULL = 3'd3, ST_MISUSE = 3'd4;
	localparam logic [1:0] ACT_ACQ = 2'd0, ACT_RETRY = 2'd1, ACT_REL = 2'd2,
		ACT_RELALL = 2'd3;
	typedef struct packed {
		logic        used;
		logic [31:0] ident;
		logic [15:0] pid;
		logic        excl;
		logic        keep;
		logic [15:0] readers;
		logic [15:0] writer;
		logic [15:0] waiters;
	} entry_t;
endpackage
`default_nettype wire

// ===== src/rwlt_mem.sv =====
// ----------------------------------------------------------------------------
// rwlt_mem
// entry store, one read and one write port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module rwlt_mem import rwlt_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES,
	localparam int AW = $clog2(ENTRIES)
) (
	input  wire logic          clk,
	input  wire logic [AW-1:0] raddr,
	output entry_t             rdata,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire entry_t        wdata
);
	entry_t mem_q [ENTRIES];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== src/reader_writer_lock_table.sv =====
// ----------------------------------------------------------------------------
// reader_writer_lock_table
// table of reader/writer locks keyed by pid and identifier
// ----------------------------------------------------------------------------
// usage: one request on the in channel (valid/stall) gives one result on the
// out channel. a request scans every slot of the entry memory, one slot per
// cycle through its single read port, then writes the chosen slot back and
// registers the result (states scan, exec, out). release-all frees each
// matching slot during its scan. one request is handled at a time, so no new
// request is taken before the last result is; stall is raised from
// acceptance until the result is taken.
// the used flags live in flip-flops that reset clears, so no clearing pass
// is needed; other entry fields are written whenever a slot is taken.
// while out_stall is high the result holds and no new request is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module reader_writer_lock_table import rwlt_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_ENTRIES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [15:0] process_id,
	input  wire logic [31:0] lock_ident,
	input  wire logic        want_exclusive,
	input  wire logic        keep_entry,
	input  wire logic [15:0] thread_id,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [5:0]       slot_index,
	output logic             wake_shared,
	output logic             wake_exclusive
);
	localparam int AW = $clog2(TABLE_ENTRIES);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_EXEC = 4'b0100, S_OUT = 4'b1000
	} state_t;
	state_t state_q;
	logic [TABLE_ENTRIES-1:0] used_q;
	logic [AW:0]   cnt_q;
	logic [AW-1:0] raddr, waddr, slot_q, free_q;
	logic          found_q, have_free_q, rv_s1, used_s1, we;
	logic [AW-1:0] ra_s1;
	logic [1:0]    act_q;
	logic [15:0]   pid_q, tid_q;
	logic [31:0]   id_q;
	logic          ex_q, kp_q;
	entry_t        rdata, wdata, hit_q, e;
	logic          hit;
	logic [2:0]    st;
	logic          wsh, wex, wr_ex, free_ex;

	rwlt_mem #(.ENTRIES(TABLE_ENTRIES)) u_mem (.clk, .raddr, .rdata, .we, .waddr, .wdata);

	assign in_stall = state_q != S_IDLE;
	assign raddr = cnt_q[AW-1:0];
	assign hit = rv_s1 && used_s1 && rdata.ident == id_q &&
		(rdata.pid == ANY_PID || rdata.pid == pid_q);

	// decide the operation on the chosen slot
	always_comb begin
		e = hit_q;
		st = ST_OK; wsh = 1'b0; wex = 1'b0; wr_ex = 1'b0; free_ex = 1'b0;
		if (!found_q) begin
			e = '0;
			e.used = 1'b1; e.ident = id_q; e.pid = pid_q; e.writer = NO_TID;
		end
		unique case (act_q) inside
			ACT_ACQ, ACT_RETRY: begin
				if (act_q == ACT_ACQ && !found_q && !have_free_q) st = ST_FULL;
				else if (act_q == ACT_RETRY && !found_q) st = ST_NOENT;
				else if (tid_q == NO_TID) st = ST_MISUSE;
				else if (act_q == ACT_ACQ && found_q && e.writer == tid_q) st = ST_MISUSE;
				else if (act_q == ACT_RETRY && e.waiters == 16'd0) st = ST_MISUSE;
				else begin
					if (act_q == ACT_RETRY) e.waiters = e.waiters - 16'd1;
					wr_ex = 1'b1;
					if (e.writer != NO_TID || (ex_q && e.readers != 16'd0)) begin
						st = ST_WAIT;
						if (e.waiters != 16'hffff) e.waiters = e.waiters + 16'd1;
					end else if (!ex_q && e.readers == 16'hffff) begin
						st = ST_MISUSE;
						wr_ex = act_q == ACT_RETRY || !found_q;
					end else begin
						e.excl = ex_q; e.keep = kp_q;
						if (ex_q) e.writer = tid_q;
						else e.readers = e.readers + 16'd1;
					end
				end
			end
			ACT_REL: begin
				if (!found_q) st = ST_NOENT;
				else if (e.excl ? e.writer == NO_TID
					: (e.readers == 16'd0 || e.writer != NO_TID)) st = ST_MISUSE;
				else begin
					wr_ex = 1'b1;
					if (e.excl) e.writer = NO_TID;
					else e.readers = e.readers - 16'd1;
					if (e.waiters != 16'd0) begin
						wsh = 1'b1; wex = e.readers == 16'd0;
					end else if (e.readers == 16'd0 && !e.keep) free_ex = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign we = state_q == S_EXEC && wr_ex;
	assign waddr = found_q ? slot_q : free_q;
	assign wdata = e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; used_q <= '0; out_valid <= 1'b0;
			cnt_q <= '0; rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= state_q == S_SCAN && cnt_q < (AW+1)'(TABLE_ENTRIES);
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_SCAN; cnt_q <= '0;
				end
				S_SCAN: begin
					if (cnt_q < (AW+1)'(TABLE_ENTRIES)) cnt_q <= cnt_q + 1'b1;
					if (!rv_s1 && cnt_q == (AW+1)'(TABLE_ENTRIES)) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (we && !found_q) used_q[free_q] <= 1'b1;
					if (free_ex) used_q[slot_q] <= 1'b0;
					out_valid <= 1'b1; state_q <= S_OUT;
				end
				S_OUT: if (!out_stall) begin
					out_valid <= 1'b0; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			// release-all frees by exact pid as each slot is read
			if (state_q == S_SCAN && act_q == ACT_RELALL && rv_s1 &&
				rdata.pid == pid_q) used_q[ra_s1] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		ra_s1 <= raddr;
		used_s1 <= used_q[raddr];
		if (state_q == S_IDLE) begin
			act_q <= action; pid_q <= process_id; id_q <= lock_ident;
			ex_q <= want_exclusive; kp_q <= keep_entry; tid_q <= thread_id;
			found_q <= 1'b0; have_free_q <= 1'b0; slot_q <= '0; free_q <= '0;
		end else if (state_q == S_SCAN && rv_s1) begin
			if (hit && !found_q) begin
				found_q <= 1'b1; slot_q <= ra_s1; hit_q <= rdata;
			end
			if (!used_s1 && !have_free_q) begin
				have_free_q <= 1'b1; free_q <= ra_s1;
			end
		end
		if (state_q == S_EXEC) begin
			status <= st; wake_shared <= wsh; wake_exclusive <= wex;
			slot_index <= (st == ST_FULL || st == ST_NOENT || act_q == ACT_RELALL) ? 6'd0
				: 6'(found_q ? slot_q : free_q);
		end
	end

`include "reader_writer_lock_table_assert.svh"
	`RWLT_ASSERT_IMP(a_stall_busy, out_valid, in_stall)
	`RWLT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status))
	`RWLT_ASSERT_IMP(a_wake, wake_exclusive && out_valid, wake_shared)
endmodule
`default_nettype wire

// ===== test/reader_writer_lock_table_checker.sv =====
// ----------------------------------------------------------------------------
// reader_writer_lock_table_checker
// predicts each lock table result from the accepted requests and compares
// every result field by field against the oldest prediction
// ----------------------------------------------------------------------------
`default_nettype none
module reader_writer_lock_table_checker import rwlt_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_ENTRIES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [15:0] process_id,
	input  wire logic [31:0] lock_ident,
	input  wire logic        want_exclusive,
	input  wire logic        keep_entry,
	input  wire logic [15:0] thread_id,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [2:0]  status,
	input  wire logic [5:0]  slot_index,
	input  wire logic        wake_shared,
	input  wire logic        wake_exclusive,
	output int               fail_count,
	output int               pending
);
	typedef struct packed {
		logic [2:0] status;
		logic [5:0] slot;
		logic       wsh;
		logic       wex;
	} lock_result_t;

	entry_t       locks [TABLE_ENTRIES];
	lock_result_t expected_results [$];

	function automatic int lookup_slot(logic [15:0] pid, logic [31:0] ident, bit allow_free);
		int free_slot;
		free_slot = -1;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (locks[i].used) begin
				if (locks[i].ident == ident && (locks[i].pid == ANY_PID || locks[i].pid == pid))
					return i;
			end else if (allow_free && free_slot < 0) begin
				free_slot = i;
			end
		end
		return free_slot;
	endfunction

	function automatic logic [2:0] take_lock(int i, logic excl, logic keep, logic [15:0] tid);
		logic clash;
		clash = excl ? (locks[i].readers != 0 || locks[i].writer != NO_TID)
			: (locks[i].writer != NO_TID);
		if (clash) begin
			if (locks[i].waiters != 16'hffff)
				locks[i].waiters++;
			return ST_WAIT;
		end
		if (!excl && locks[i].readers == 16'hffff)
			return ST_MISUSE;
		locks[i].excl = excl;
		locks[i].keep = keep;
		if (excl)
			locks[i].writer = tid;
		else
			locks[i].readers++;
		return ST_OK;
	endfunction

	function automatic lock_result_t predict_lock_op(logic [1:0] act, logic [15:0] pid,
			logic [31:0] ident, logic excl, logic keep, logic [15:0] tid);
		lock_result_t r;
		int i;
		r = '0;
		r.status = ST_OK;
		case (act)
			ACT_ACQ: begin
				i = lookup_slot(pid, ident, 1'b1);
				if (i < 0) begin
					r.status = ST_FULL;
				end else begin
					r.slot = i[5:0];
					if (tid == NO_TID) begin
						r.status = ST_MISUSE;
					end else if (locks[i].used) begin
						r.status = (locks[i].writer == tid) ? ST_MISUSE
							: take_lock(i, excl, keep, tid);
					end else begin
						locks[i].used = 1'b1;
						locks[i].ident = ident;
						locks[i].pid = pid;
						locks[i].readers = '0;
						locks[i].writer = NO_TID;
						locks[i].waiters = '0;
						r.status = take_lock(i, excl, keep, tid);
					end
				end
			end
			ACT_RETRY: begin
				i = lookup_slot(pid, ident, 1'b0);
				if (i < 0) begin
					r.status = ST_NOENT;
				end else begin
					r.slot = i[5:0];
					if (tid == NO_TID || locks[i].waiters == 0) begin
						r.status = ST_MISUSE;
					end else begin
						locks[i].waiters--;
						r.status = take_lock(i, excl, keep, tid);
					end
				end
			end
			ACT_REL: begin
				i = lookup_slot(pid, ident, 1'b0);
				if (i < 0) begin
					r.status = ST_NOENT;
				end else begin
					r.slot = i[5:0];
					if (locks[i].excl) begin
						if (locks[i].writer == NO_TID)
							r.status = ST_MISUSE;
						else
							locks[i].writer = NO_TID;
					end else begin
						if (locks[i].readers == 0 || locks[i].writer != NO_TID)
							r.status = ST_MISUSE;
						else
							locks[i].readers--;
					end
					if (r.status == ST_OK) begin
						if (locks[i].waiters != 0) begin
							r.wsh = 1'b1;
							r.wex = (locks[i].readers == 0);
						end else if (locks[i].readers == 0 && !locks[i].keep) begin
							locks[i].used = 1'b0;
						end
					end
				end
			end
			default: begin
				for (int k = 0; k < TABLE_ENTRIES; k++)
					if (locks[k].used && locks[k].pid == pid)
						locks[k].used = 1'b0;
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		lock_result_t e;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++)
				locks[i] = '0;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(predict_lock_op(action, process_id, lock_ident,
					want_exclusive, keep_entry, thread_id));
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", status, -1);
				end else begin
					e = expected_results.pop_front();
					if (status !== e.status)
						report_mismatch("status", status, e.status);
					if (slot_index !== e.slot)
						report_mismatch("slot_index", slot_index, e.slot);
					if (wake_shared !== e.wsh)
						report_mismatch("wake_shared", wake_shared, e.wsh);
					if (wake_exclusive !== e.wex)
						report_mismatch("wake_exclusive", wake_exclusive, e.wex);
				end
			end
		end
		pending = expected_results.size();
	end
endmodule
`default_nettype wire

// ===== test/reader_writer_lock_table_test.sv =====
// ----------------------------------------------------------------------------
// reader_writer_lock_table_test
// drives directed and random lock requests with random gaps and stalls;
// the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
`default_nettype none
module reader_writer_lock_table_test import rwlt_pkg::*;;

	localparam int RANDOM_REQUESTS = 1200;
	localparam int CYCLE_LIMIT = 5000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  action = ACT_ACQ;
	logic [15:0] process_id = '0;
	logic [31:0] lock_ident = '0;
	logic        want_exclusive = 1'b0;
	logic        keep_entry = 1'b0;
	logic [15:0] thread_id = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [5:0]  slot_index;
	logic        wake_shared;
	logic        wake_exclusive;
	int          fail_count;
	int          pending;
	int          cycles = 0;
	int          stall_left = 0;
	logic [31:0] ident_pool [8];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	reader_writer_lock_table DUT (.*);

	reader_writer_lock_table_checker checker_i (.*);

	function automatic int gap_length();
		if ($urandom_range(0, 3) == 0)
			return 0;
		return ($urandom_range(0, 15) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
	endfunction

	// receiver side: stall runs of random length, sometimes long
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			stall_left <= gap_length();
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_request(logic [1:0] act, logic [15:0] pid, logic [31:0] ident,
			logic excl, logic keep, logic [15:0] tid);
		int n;
		action <= act;
		process_id <= pid;
		lock_ident <= ident;
		want_exclusive <= excl;
		keep_entry <= keep;
		thread_id <= tid;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		n = gap_length();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic random_request();
		logic [1:0]  act;
		logic [15:0] pid;
		logic [31:0] ident;
		logic [15:0] tid;
		// mostly a small set of pids and identifiers so that locks collide
		if ($urandom_range(0, 9) == 0) begin
			act = 2'($urandom_range(0, 3));
			pid = 16'($urandom);
			ident = $urandom;
			tid = 16'($urandom);
		end else begin
			act = ($urandom_range(0, 19) == 0) ? ACT_RELALL : 2'($urandom_range(0, 2));
			pid = ($urandom_range(0, 7) == 0) ? ANY_PID : 16'($urandom_range(0, 3));
			ident = ident_pool[$urandom_range(0, 7)];
			tid = ($urandom_range(0, 30) == 0) ? NO_TID : 16'($urandom_range(1, 6));
		end
		send_request(act, pid, ident, 1'($urandom_range(0, 1)), $urandom_range(0, 2) != 0,
			tid);
	endtask

	initial begin
		int waited;
		ident_pool[0] = 32'h0;
		ident_pool[1] = 32'hffff_ffff;
		for (int i = 2; i < 8; i++)
			ident_pool[i] = $urandom;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, each action and the misuse cases
		send_request(ACT_ACQ, 16'h0, 32'h0, 1'b1, 1'b0, 16'h1);
		send_request(ACT_ACQ, 16'h0, 32'h0, 1'b1, 1'b0, 16'h1);       // self deadlock
		send_request(ACT_ACQ, 16'h0, 32'h0, 1'b0, 1'b0, 16'h2);       // must wait
		send_request(ACT_ACQ, 16'h0, 32'h0, 1'b0, 1'b0, NO_TID);      // reserved thread id
		send_request(ACT_REL, 16'h0, 32'h0, 1'b0, 1'b0, 16'h1);       // wakes waiters
		send_request(ACT_RETRY, 16'h0, 32'h0, 1'b0, 1'b1, 16'h2);
		send_request(ACT_RETRY, 16'h0, 32'h0, 1'b0, 1'b1, 16'h2);     // no waiter
		send_request(ACT_RETRY, 16'h5, 32'h5, 1'b0, 1'b0, 16'h2);     // no such lock
		send_request(ACT_REL, 16'h0, 32'h0, 1'b0, 1'b0, 16'h2);
		send_request(ACT_REL, 16'h0, 32'h0, 1'b0, 1'b0, 16'h2);       // release without hold
		send_request(ACT_ACQ, ANY_PID, 32'hffff_ffff, 1'b0, 1'b1, 16'hfffe);
		send_request(ACT_ACQ, 16'h1234, 32'hffff_ffff, 1'b0, 1'b1, 16'h3);
		send_request(ACT_REL, 16'hffff, 32'hffff_ffff, 1'b1, 1'b0, 16'h3);
		send_request(ACT_RELALL, ANY_PID, 32'h0, 1'b0, 1'b0, 16'h0);
		// fill the rest of the table, then two more for table full
		for (int i = 0; i < 65; i++)
			send_request(ACT_ACQ, 16'h7, 32'h100 + i, 1'b0, 1'b0, 16'h1);
		send_request(ACT_RELALL, 16'h7, 32'h0, 1'b0, 1'b0, 16'h0);

		for (int n = 0; n < RANDOM_REQUESTS; n++)
			random_request();
		in_valid <= 1'b0;

		waited = 0;
		while (pending != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
